// ===== rtl/charlieplex_bcm_led_scanner_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef CHARLIEPLEX_BCM_LED_SCANNER_MACROS_SVH
`define CHARLIEPLEX_BCM_LED_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CBLS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CBLS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbls_pkg.sv =====
// Shared constants and types for the charlieplex BCM LED scanner.
package cbls_pkg;

    // Word field widths
    localparam int unsigned ROW_W       = 5;
    localparam int unsigned COL_W       = 5;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned PINS_OUT_W  = 20;
    localparam int unsigned ANODE_W     = 5;
    localparam int unsigned PLANE_OUT_W = 3;
    localparam int unsigned PLANE_MAX_W = 4;

    // Configuration
    localparam int unsigned BASE_W     = 10;
    localparam int unsigned BASE_RESET = 25;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register select (paddr bit 2)
    localparam logic REG_BASE_UNIT = 1'b0;

    // Commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Scan position handed to the drive generator
    typedef struct packed {
        logic [ANODE_W-1:0]     anode;
        logic [PLANE_MAX_W-1:0] plane;
    } t_scan_pos;

endpackage

// ===== rtl/cbls_if.sv =====
// Valid/ready channel interfaces for scanner commands and drive results.
interface cbls_in_if;
    import cbls_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [ROW_W-1:0]   pixel_row;
    logic [COL_W-1:0]   pixel_col;
    logic [LEVEL_W-1:0] pixel_level;

    modport source (
        output valid, command, pixel_row, pixel_col, pixel_level,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_row, pixel_col, pixel_level,
        output ready
    );
endinterface

interface cbls_out_if;
    import cbls_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PINS_OUT_W-1:0]  pin_drive_enable;
    logic [PINS_OUT_W-1:0]  pin_drive_high;
    logic                   scan_stepped;
    logic [ANODE_W-1:0]     active_anode;
    logic [PLANE_OUT_W-1:0] active_plane;

    modport source (
        output valid, pin_drive_enable, pin_drive_high, scan_stepped,
               active_anode, active_plane,
        input  ready
    );
    modport sink (
        input  valid, pin_drive_enable, pin_drive_high, scan_stepped,
               active_anode, active_plane,
        output ready
    );
endinterface

// ===== rtl/cbls_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cbls_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cbls_drive_gen.sv =====
// Builds the pin enable and high masks for one anode row and bit-plane.
module cbls_drive_gen #(
    parameter int unsigned PIN_COUNT  = 20,
    parameter int unsigned LEVEL_BITS = 8
) (
    input  cbls_pkg::t_scan_pos                      i_pos,
    input  logic [(PIN_COUNT-1)*LEVEL_BITS-1:0]      i_row,
    output logic [PIN_COUNT-1:0]                     o_en,
    output logic [PIN_COUNT-1:0]                     o_hi
);
    import cbls_pkg::*;

    localparam int unsigned COLS = PIN_COUNT - 1;
    localparam int unsigned PW   = (LEVEL_BITS > 1) ? $clog2(LEVEL_BITS) : 1;

    logic [PW-1:0] w_plane;
    assign w_plane = i_pos.plane[PW-1:0];

    for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
        logic w_below;
        logic w_above;

        // pin below the anode maps to column p, above it to column p-1
        if (p < COLS) begin : g_lo
            assign w_below = i_row[p*LEVEL_BITS + w_plane];
        end else begin : g_lo_none
            assign w_below = 1'b0;
        end
        if (p > 0) begin : g_hi
            assign w_above = i_row[(p-1)*LEVEL_BITS + w_plane];
        end else begin : g_hi_none
            assign w_above = 1'b0;
        end

        assign o_hi[p] = (i_pos.anode == ANODE_W'(p));
        assign o_en[p] = o_hi[p] | ((ANODE_W'(p) < i_pos.anode) ? w_below : w_above);
    end
endmodule

// ===== rtl/charlieplex_bcm_led_scanner.sv =====
// Top level: charlieplexed LED scanner with binary code modulation.
//
//  port    dir  handshake        carries
//  i_in    in   valid/ready      command, pixel_row, pixel_col, pixel_level
//  o_out   out  valid/ready      pin masks, scan_stepped, anode, plane
//  apb     in   psel/penable     base_unit_ticks at 0x0
//
//  One word per cycle while the output is not held; the frame row is read at the
//  accepting edge into the update stage, which then registers the result into the
//  output register, from which it can be taken.
//  The frame store holds one row of all column levels per entry, so a step
//  needs a single read of the incoming anode's row.
//  Reset clears the per-row valid flags; unwritten rows read as zero, no sweep.
//  A held output stalls input only once the update stage is also full.
`include "charlieplex_bcm_led_scanner_macros.svh"

module charlieplex_bcm_led_scanner #(
    parameter int unsigned PIN_COUNT  = 20,
    parameter int unsigned LEVEL_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cbls_in_if.sink                           i_in,
    cbls_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cbls_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cbls_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cbls_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import cbls_pkg::*;

    localparam int unsigned COLS     = PIN_COUNT - 1;
    localparam int unsigned ROW_BITS = COLS * LEVEL_BITS;
    localparam int unsigned AW       = $clog2(PIN_COUNT);
    localparam int unsigned PW       = (LEVEL_BITS > 1) ? $clog2(LEVEL_BITS) : 1;
    localparam int unsigned CNT_W    = BASE_W + LEVEL_BITS;

    // ---------------- configuration ----------------
    logic [BASE_W-1:0] r_base;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BASE_UNIT) ?
                    {{(CFG_DATA_W-BASE_W){1'b0}}, r_base} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_W'(BASE_RESET);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BASE_UNIT) begin
            r_base <= pwdata[BASE_W-1:0];
        end
    end

    // ---------------- scan state ----------------
    logic [AW-1:0]        r_anode,    n_anode;
    logic [PW-1:0]        r_plane,    n_plane;
    logic [CNT_W-1:0]     r_count,    n_count;
    logic                 r_started,  n_started;
    logic [PIN_COUNT-1:0] r_drive_en, n_drive_en;
    logic [PIN_COUNT-1:0] r_drive_hi, n_drive_hi;
    logic [PIN_COUNT-1:0] r_row_valid;

    // update stage
    logic                  r_s1_valid;
    logic                  r_s1_cmd;
    logic [AW-1:0]         r_s1_row;
    logic [COL_W-1:0]      r_s1_col;
    logic [LEVEL_BITS-1:0] r_s1_level;
    logic                  r_s1_ok;
    logic                  r_s1_fwd;
    logic [ROW_BITS-1:0]   r_s1_fwd_data;

    // output register
    logic                   r_o_valid;
    logic [PINS_OUT_W-1:0]  r_o_en;
    logic [PINS_OUT_W-1:0]  r_o_hi;
    logic                   r_o_stepped;
    logic [ANODE_W-1:0]     r_o_anode;
    logic [PLANE_OUT_W-1:0] r_o_plane;

    logic                  s1_fire;
    logic                  s1_step;
    logic                  s1_wr_en;
    logic                  accept;
    logic [AW-1:0]         anode_eff;
    logic [AW-1:0]         anode_look;
    logic [AW-1:0]         rd_addr;
    logic                  in_ok;
    logic [LEVEL_BITS+LEVEL_W-1:0] level_ext;
    logic [ROW_BITS-1:0]   ram_rdata;
    logic [ROW_BITS-1:0]   row_data;
    logic [ROW_BITS-1:0]   wr_row;
    logic [BASE_W-1:0]     base_eff;
    logic [PW-1:0]         plane_step;
    logic [CNT_W-1:0]      dur;
    t_scan_pos             scan_pos;
    logic [PIN_COUNT-1:0]  gen_en;
    logic [PIN_COUNT-1:0]  gen_hi;
    logic [PIN_COUNT+PINS_OUT_W-1:0]  en_ext;
    logic [PIN_COUNT+PINS_OUT_W-1:0]  hi_ext;
    logic [AW+ANODE_W-1:0]            anode_ext;
    logic [PW+PLANE_OUT_W-1:0]        plane_ext;

    function automatic logic [AW-1:0] anode_next(input logic [AW-1:0] a);
        return (a == AW'(PIN_COUNT - 1)) ? '0 : a + 1'b1;
    endfunction

    // handshake
    assign s1_fire    = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign accept     = i_in.valid && i_in.ready;

    assign s1_step  = (r_s1_cmd == CMD_TICK) && (r_count <= CNT_W'(1));
    assign s1_wr_en = s1_fire && (r_s1_cmd == CMD_WRITE) && r_s1_ok;

    // a tick fetches the row of the anode that follows the one in force
    // once the update stage retires
    assign anode_eff  = (s1_fire && s1_step) ? r_s1_row : r_anode;
    assign anode_look = anode_next(anode_eff);

    assign in_ok = ({1'b0, i_in.pixel_row} < (ROW_W+1)'(PIN_COUNT)) &&
                   ({1'b0, i_in.pixel_col} < (COL_W+1)'(COLS));
    assign rd_addr   = (i_in.command == CMD_WRITE) ? i_in.pixel_row[AW-1:0] : anode_look;
    assign level_ext = {{LEVEL_BITS{1'b0}}, i_in.pixel_level};

    cbls_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (PIN_COUNT)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (s1_wr_en),
        .i_waddr (r_s1_row),
        .i_wdata (wr_row),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // the row written in the read cycle is forwarded, never-written rows read zero
    assign row_data = r_s1_fwd ? r_s1_fwd_data :
                      (r_row_valid[r_s1_row] ? ram_rdata : '0);

    always_comb begin
        wr_row = row_data;
        for (int c = 0; c < COLS; c++) begin
            if (r_s1_col == COL_W'(c)) begin
                wr_row[c*LEVEL_BITS +: LEVEL_BITS] = r_s1_level;
            end
        end
    end

    // step timing: base * (2^plane + 1)
    assign base_eff   = (r_base == '0) ? BASE_W'(1) : r_base;
    assign plane_step = (r_s1_row != '0) ? r_plane :
                        ((r_plane == PW'(LEVEL_BITS - 1)) ? '0 : r_plane + 1'b1);
    assign dur        = (CNT_W'(base_eff) << plane_step) + CNT_W'(base_eff);

    assign scan_pos.anode = ANODE_W'(r_s1_row);
    assign scan_pos.plane = PLANE_MAX_W'(plane_step);

    cbls_drive_gen #(
        .PIN_COUNT  (PIN_COUNT),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_drive (
        .i_pos (scan_pos),
        .i_row (row_data),
        .o_en  (gen_en),
        .o_hi  (gen_hi)
    );

    always_comb begin
        n_anode    = r_anode;
        n_plane    = r_plane;
        n_count    = r_count;
        n_started  = r_started;
        n_drive_en = r_drive_en;
        n_drive_hi = r_drive_hi;
        if (s1_fire && r_s1_cmd == CMD_TICK) begin
            if (s1_step) begin
                n_anode    = r_s1_row;
                n_plane    = plane_step;
                n_count    = dur;
                n_started  = 1'b1;
                n_drive_en = gen_en;
                n_drive_hi = gen_hi;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    assign en_ext    = {{PINS_OUT_W{1'b0}}, (n_started ? n_drive_en : '0)};
    assign hi_ext    = {{PINS_OUT_W{1'b0}}, (n_started ? n_drive_hi : '0)};
    assign anode_ext = {{ANODE_W{1'b0}}, n_anode};
    assign plane_ext = {{PLANE_OUT_W{1'b0}}, n_plane};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anode     <= '0;
            r_plane     <= '0;
            r_count     <= CNT_W'(2 * BASE_RESET);
            r_started   <= 1'b0;
            r_drive_en  <= '0;
            r_drive_hi  <= '0;
            r_row_valid <= '0;
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_anode    <= n_anode;
            r_plane    <= n_plane;
            r_count    <= n_count;
            r_started  <= n_started;
            r_drive_en <= n_drive_en;
            r_drive_hi <= n_drive_hi;
            if (s1_wr_en) begin
                r_row_valid[r_s1_row] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd      <= i_in.command;
            r_s1_row      <= rd_addr;
            r_s1_col      <= i_in.pixel_col;
            r_s1_level    <= level_ext[LEVEL_BITS-1:0];
            r_s1_ok       <= in_ok;
            r_s1_fwd      <= s1_wr_en && (r_s1_row == rd_addr);
            r_s1_fwd_data <= wr_row;
        end
        if (s1_fire) begin
            r_o_en      <= en_ext[PINS_OUT_W-1:0];
            r_o_hi      <= hi_ext[PINS_OUT_W-1:0];
            r_o_stepped <= s1_step;
            r_o_anode   <= anode_ext[ANODE_W-1:0];
            r_o_plane   <= plane_ext[PLANE_OUT_W-1:0];
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.pin_drive_enable = r_o_en;
    assign o_out.pin_drive_high   = r_o_hi;
    assign o_out.scan_stepped     = r_o_stepped;
    assign o_out.active_anode     = r_o_anode;
    assign o_out.active_plane     = r_o_plane;

    // ---------------- assertions ----------------
    `CBLS_ASSERT_NEXT(a_step_reported, i_clk, i_rst_n, s1_fire && s1_step, o_out.valid && o_out.scan_stepped, "step end not reported in the next word")
    `CBLS_ASSERT_NOW(a_count_live, i_clk, i_rst_n, 1'b1, r_count != '0 && r_anode < AW'(PIN_COUNT - 1) + 1'b1 || r_count != '0 && r_anode == AW'(PIN_COUNT - 1), "countdown zero or anode out of range")
    `CBLS_ASSERT_NOW(a_one_anode, i_clk, i_rst_n, r_started, $onehot(r_drive_hi) && ((r_drive_hi & r_drive_en) == r_drive_hi), "drive must source exactly one enabled anode")

endmodule

// ===== sim/charlieplex_bcm_led_scanner_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the charlieplex BCM scanner: pixel writes and ticks against a scan model.
module charlieplex_bcm_led_scanner_tb;
    import cbls_pkg::*;

    localparam int unsigned PINS           = 20;
    localparam int unsigned COLS           = PINS - 1;
    localparam int unsigned PLANES         = 8;
    localparam int unsigned STALL_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS    = 100;

    localparam logic [CFG_ADDR_W-1:0] ADDR_BASE_UNIT = {REG_BASE_UNIT, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED    = {~REG_BASE_UNIT, 2'b00};

    typedef struct packed {
        logic               command;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [LEVEL_W-1:0] level;
    } scan_word_t;

    typedef struct packed {
        logic [PINS_OUT_W-1:0]  enable;
        logic [PINS_OUT_W-1:0]  high;
        logic                   stepped;
        logic [ANODE_W-1:0]     anode;
        logic [PLANE_OUT_W-1:0] plane;
    } drive_word_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cbls_in_if  in_if ();
    cbls_out_if out_if ();

    charlieplex_bcm_led_scanner #(
        .PIN_COUNT  (PINS),
        .LEVEL_BITS (PLANES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Scan model state
    logic [LEVEL_W-1:0]    frame_levels [PINS][COLS];
    int unsigned           scan_anode;
    int unsigned           scan_plane;
    int unsigned           ticks_left;
    logic                  drive_live;
    logic [PINS_OUT_W-1:0] live_enable;
    logic [PINS_OUT_W-1:0] live_high;
    logic [BASE_W-1:0]     base_unit;

    scan_word_t  word_queue [$];
    drive_word_t drive_expected [$];
    scan_word_t  word_on_bus;

    bit          src_gaps        = 1'b1;
    bit          sink_gaps       = 1'b1;
    int unsigned stall_req       = 0;
    int unsigned stall_ack       = 0;
    int unsigned hold_left       = 0;
    int unsigned idle_cycles     = 0;
    int unsigned fail_count      = 0;
    int unsigned words_accepted  = 0;
    int unsigned writes_accepted = 0;
    int unsigned steps_predicted = 0;
    int unsigned plane_wraps     = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned step_ticks(int unsigned plane);
        int unsigned units;
        units = (base_unit == '0) ? 1 : 32'(base_unit);
        return units * ((1 << plane) + 1);
    endfunction

    function automatic void reset_scan_model();
        foreach (frame_levels[r, c]) frame_levels[r][c] = '0;
        base_unit   = BASE_W'(BASE_RESET);
        scan_anode  = 0;
        scan_plane  = 0;
        ticks_left  = step_ticks(0);
        drive_live  = 1'b0;
        live_enable = '0;
        live_high   = '0;
    endfunction

    function automatic drive_word_t advance_scan(scan_word_t w);
        drive_word_t r;
        int unsigned col;
        r.stepped = 1'b0;
        if (w.command == CMD_WRITE) begin
            if (w.row < PINS && w.col < COLS) frame_levels[w.row][w.col] = w.level;
        end else if (ticks_left > 1) begin
            ticks_left--;
        end else begin
            scan_anode++;
            if (scan_anode >= PINS) begin
                scan_anode = 0;
                scan_plane++;
                if (scan_plane >= PLANES) begin
                    scan_plane = 0;
                    plane_wraps++;
                end
            end
            ticks_left = step_ticks(scan_plane);
            live_high = '0;
            live_high[scan_anode] = 1'b1;
            live_enable = live_high;
            // cathode column skips the anode's own pin
            for (int unsigned p = 0; p < PINS; p++) begin
                if (p != scan_anode) begin
                    col = (p < scan_anode) ? p : p - 1;
                    if (frame_levels[scan_anode][col][scan_plane]) live_enable[p] = 1'b1;
                end
            end
            drive_live = 1'b1;
            r.stepped = 1'b1;
            steps_predicted++;
        end
        r.enable = drive_live ? live_enable : '0;
        r.high   = drive_live ? live_high : '0;
        r.anode  = scan_anode[ANODE_W-1:0];
        r.plane  = scan_plane[PLANE_OUT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    function automatic scan_word_t rand_word(int unsigned tick_pct);
        scan_word_t w;
        w.command = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_WRITE;
        // mostly in range, the rest lands on rows and columns that must be ignored
        w.row   = ($urandom_range(99) < 90) ? ROW_W'($urandom_range(PINS - 1))
                                            : ROW_W'($urandom_range((1 << ROW_W) - 1, PINS));
        w.col   = ($urandom_range(99) < 90) ? COL_W'($urandom_range(COLS - 1))
                                            : COL_W'($urandom_range((1 << COL_W) - 1, COLS));
        w.level = LEVEL_W'($urandom_range((1 << LEVEL_W) - 1));
        return w;
    endfunction

    task automatic queue_word(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                              logic [LEVEL_W-1:0] level);
        word_queue.push_back('{cmd, row, col, level});
    endtask

    task automatic queue_random(int unsigned count, int unsigned tick_pct);
        repeat (count) word_queue.push_back(rand_word(tick_pct));
    endtask

    task automatic wait_drained();
        while (word_queue.size() != 0 || in_if.valid || drive_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data,
                              output logic [CFG_DATA_W-1:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_base_unit(logic [CFG_DATA_W-1:0] data);
        logic [CFG_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_BASE_UNIT, data, rd);
        base_unit = data[BASE_W-1:0];
        apb_access(1'b0, ADDR_BASE_UNIT, '0, rd);
        check_field("base_unit_ticks readback", 32'(base_unit), rd);
    endtask

    // Source: holds a word until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                drive_expected.push_back(advance_scan(word_on_bus));
                words_accepted++;
                if (word_on_bus.command == CMD_WRITE) writes_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (word_queue.size() != 0 && !(src_gaps && $urandom_range(99) < 31)) begin
                    word_on_bus = word_queue.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.command     <= word_on_bus.command;
                    in_if.pixel_row   <= word_on_bus.row;
                    in_if.pixel_col   <= word_on_bus.col;
                    in_if.pixel_level <= word_on_bus.level;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Sink ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (stall_req != stall_ack) begin
            out_if.ready <= 1'b0;
            stall_ack    <= stall_req;
            hold_left    <= STALL_CYCLES;
        end else begin
            out_if.ready <= !(sink_gaps && ($urandom_range(99) < 31));
        end
    end

    always @(posedge i_clk) begin : drive_monitor
        drive_word_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (drive_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) $error("drive word with nothing outstanding");
            end else begin
                want = drive_expected.pop_front();
                check_field("pin_drive_enable", 32'(want.enable), 32'(out_if.pin_drive_enable));
                check_field("pin_drive_high", 32'(want.high), 32'(out_if.pin_drive_high));
                check_field("scan_stepped", 32'(want.stepped), 32'(out_if.scan_stepped));
                check_field("active_anode", 32'(want.anode), 32'(out_if.active_anode));
                check_field("active_plane", 32'(want.plane), 32'(out_if.active_plane));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] rd;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.command     = CMD_TICK;
        in_if.pixel_row   = '0;
        in_if.pixel_col   = '0;
        in_if.pixel_level = '0;
        out_if.ready      = 1'b0;
        reset_scan_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pins float before the first step, corner pixels, ignored writes
        queue_word(CMD_TICK, '0, '0, '0);
        queue_word(CMD_TICK, '1, '1, '1);
        queue_word(CMD_WRITE, ROW_W'(0), COL_W'(0), 8'hFF);
        queue_word(CMD_WRITE, ROW_W'(0), COL_W'(COLS - 1), 8'hAA);
        queue_word(CMD_WRITE, ROW_W'(PINS - 1), COL_W'(0), 8'h55);
        queue_word(CMD_WRITE, ROW_W'(PINS - 1), COL_W'(COLS - 1), 8'hFF);
        queue_word(CMD_WRITE, ROW_W'(PINS - 1), COL_W'(COLS - 1), 8'h00);
        queue_word(CMD_WRITE, ROW_W'(PINS - 1), COL_W'(COLS - 1), 8'h0F);
        queue_word(CMD_WRITE, ROW_W'(1), COL_W'(0), 8'h80);
        queue_word(CMD_WRITE, ROW_W'(1), COL_W'(COLS - 1), 8'h01);
        queue_word(CMD_WRITE, ROW_W'(1), COL_W'(1), 8'h7F);
        queue_word(CMD_WRITE, ROW_W'(2), COL_W'(1), 8'hFE);
        queue_word(CMD_WRITE, ROW_W'(PINS), COL_W'(0), 8'hFF);
        queue_word(CMD_WRITE, '1, '1, 8'hFF);
        queue_word(CMD_WRITE, ROW_W'(0), COL_W'(COLS), 8'hFF);
        queue_word(CMD_WRITE, ROW_W'(7), '1, 8'hFF);
        queue_word(CMD_WRITE, '1, COL_W'(COLS - 1), 8'h00);
        queue_word(CMD_TICK, 5'h15, 5'h0A, 8'h5A);
        queue_word(CMD_TICK, '1, '1, '1);
        queue_word(CMD_TICK, '0, '0, '0);
        wait_drained();

        // Reset base unit, then base zero which must act as one
        queue_random(100, 75);
        wait_drained();
        set_base_unit({22'h3FFFFF, 10'h000});
        queue_random(100, 80);
        wait_drained();

        // Base one with the sink held off while the source keeps offering
        set_base_unit(32'd1);
        src_gaps = 1'b0;
        stall_req++;
        queue_random(200, 75);
        wait_drained();
        src_gaps = 1'b1;

        set_base_unit(32'd1023);
        queue_random(60, 80);
        wait_drained();

        // Write to an unused address must leave the base unit alone
        apb_access(1'b1, ADDR_UNUSED, $urandom, rd);
        apb_access(1'b0, ADDR_BASE_UNIT, '0, rd);
        check_field("base_unit_ticks after unused write", 32'(base_unit), rd);

        set_base_unit({22'($urandom_range(4194303)), 10'($urandom_range(40, 2))});
        queue_random(120, 75);
        wait_drained();

        // Fast burst with no gaps on either side
        set_base_unit(32'd1);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        queue_random(150, 92);
        wait_drained();

        if (drive_expected.size() != 0) begin
            fail_count++;
            $error("%0d drive words never arrived", drive_expected.size());
        end
        $display("Covered %0d words (%0d pixel writes) and %0d scan steps", words_accepted,
                 writes_accepted, steps_predicted);
        $display("Base units 25, 0, 1, 1023 and a random one; last plane %0d, plane wraps %0d",
                 scan_plane, plane_wraps);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
